// ===== rtl/mfa_pkg.sv =====
// Shared types and constants for the mixed fraction ALU.
package mfa_pkg;

  localparam int unsigned WholeBitsDefault = 16;
  localparam int unsigned FracBitsDefault  = 12;
  localparam int unsigned OutWholeBits     = 41;
  localparam int unsigned OutFracBits      = 40;
  localparam int unsigned ProdBits         = 56;
  localparam int unsigned MagBits          = 55;
  localparam int unsigned QueueDepth       = 2;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  // Classified item handed from front to back: numerator and denominator.
  typedef struct packed {
    logic                       zero_den;
    logic signed [ProdBits-1:0] p;
    logic signed [ProdBits-1:0] q;
  } frac_t;

endpackage

// ===== rtl/mfa_front.sv =====
// Front end: forms improper fractions and cross-multiplies in the StImp, StCross1 and StCross2 states.
module mfa_front #(
  parameter int unsigned WholeBits = mfa_pkg::WholeBitsDefault,
  parameter int unsigned FracBits  = mfa_pkg::FracBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [1:0]                  func_i,
  input  logic signed [WholeBits-1:0] left_whole_i,
  input  logic [FracBits-1:0]         left_num_i,
  input  logic [FracBits-1:0]         left_den_i,
  input  logic signed [WholeBits-1:0] right_whole_i,
  input  logic [FracBits-1:0]         right_num_i,
  input  logic [FracBits-1:0]         right_den_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output mfa_pkg::frac_t              item_o
);

  localparam int unsigned PB = mfa_pkg::ProdBits;
  localparam int unsigned DB = FracBits + 1;
  // improper numerator width
  localparam int unsigned IB = WholeBits + FracBits + 2;

  typedef enum logic [2:0] {
    StIdle, StImp, StCross1, StCross2, StDone
  } state_e;

  state_e state_q;
  logic [1:0] op_q;
  logic signed [WholeBits-1:0] lw_q, rw_q;
  logic signed [DB-1:0] ld_q, rd_q, ln_q, rn_q;
  logic signed [IB-1:0] lp_q, rp_q;
  logic signed [PB-1:0] t1_q, t2_q, q_q;
  logic signed [PB-1:0] p_w;
  logic signed [DB+WholeBits-1:0] mul_lw, mul_rw;
  logic signed [DB+IB-1:0] mul_rl, mul_lr;
  logic signed [IB+IB-1:0] mul_pp;
  logic signed [DB+DB-1:0] mul_dd;

  assign full_o  = (state_q != StIdle);
  assign valid_o = (state_q == StDone);

  assign mul_lw = ld_q * lw_q;
  assign mul_rw = rd_q * rw_q;
  assign mul_rl = rd_q * lp_q;
  assign mul_lr = ld_q * rp_q;
  assign mul_pp = lp_q * rp_q;
  assign mul_dd = ld_q * rd_q;

  always_comb begin
    case (mfa_pkg::op_e'(op_q))
      mfa_pkg::OpAdd: p_w = t1_q + t2_q;
      mfa_pkg::OpSub: p_w = t1_q - t2_q;
      default:        p_w = t1_q;
    endcase
  end

  assign item_o.p        = p_w;
  assign item_o.q        = q_q;
  assign item_o.zero_den = (q_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (push_i) begin
          state_q <= StImp;
          op_q <= func_i;
          lw_q <= left_whole_i;
          rw_q <= right_whole_i;
          ln_q <= signed'({1'b0, left_num_i});
          rn_q <= signed'({1'b0, right_num_i});
          ld_q <= signed'({1'b0, left_den_i});
          rd_q <= signed'({1'b0, right_den_i});
        end
        StImp: begin
          lp_q <= IB'(mul_lw) + IB'(ln_q);
          rp_q <= IB'(mul_rw) + IB'(rn_q);
          state_q <= StCross1;
        end
        StCross1: begin
          if (op_q == mfa_pkg::OpMul) t1_q <= PB'(mul_pp);
          else                        t1_q <= PB'(mul_rl);
          t2_q <= PB'(mul_lr);
          state_q <= StCross2;
        end
        StCross2: begin
          if (op_q == mfa_pkg::OpDiv) q_q <= t2_q;
          else                        q_q <= PB'(mul_dd);
          state_q <= StDone;
        end
        StDone: if (ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/mfa_queue.sv =====
// Short queue between front and back ends.
module mfa_queue #(
  parameter int unsigned Depth = mfa_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mfa_pkg::frac_t data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output mfa_pkg::frac_t data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  mfa_pkg::frac_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/mfa_back.sv =====
// Back end: floor division, Euclid GCD and reduction on one shared divider.
module mfa_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  mfa_pkg::frac_t                    item_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [mfa_pkg::OutWholeBits-1:0] result_whole_o,
  output logic [mfa_pkg::OutFracBits-1:0]   result_num_o,
  output logic [mfa_pkg::OutFracBits-1:0]   result_den_o,
  output logic                              zero_denominator_o
);

  localparam int unsigned MB = mfa_pkg::MagBits;
  localparam int unsigned CB = $clog2(MB + 1);
  localparam int unsigned OW = mfa_pkg::OutWholeBits;
  localparam int unsigned OF = mfa_pkg::OutFracBits;

  typedef enum logic [3:0] {
    StIdle, StWDiv, StWFix, StGcdStart, StGcdDiv, StGcdStep,
    StRNum, StRDen, StRDone, StOut
  } state_e;

  state_e state_q;
  logic neg_q;
  logic [MB-1:0] q_q, w_q, r_q, x_q, y_q, g_q;
  // Shared restoring divider.
  logic [MB-1:0] dn_q, dd_q, quo_q, rem_q;
  logic [CB-1:0] cnt_q;
  logic          dbusy_q;
  logic [MB:0]   trial;
  logic signed [mfa_pkg::ProdBits-1:0] p_n, q_n;
  logic signed [OW-1:0] whole_q;
  logic [OF-1:0] num_q, den_q;
  logic zd_q;

  assign ready_o = (state_q == StIdle);
  assign empty_o = (state_q != StOut);
  assign result_whole_o = whole_q;
  assign result_num_o = num_q;
  assign result_den_o = den_q;
  assign zero_denominator_o = zd_q;

  assign trial = {rem_q, dn_q[MB-1]} - {1'b0, dd_q};

  always_comb begin
    p_n = item_i.q[mfa_pkg::ProdBits-1] ? -item_i.p : item_i.p;
    q_n = item_i.q[mfa_pkg::ProdBits-1] ? -item_i.q : item_i.q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dbusy_q <= 1'b0;
    end else begin
      if (dbusy_q) begin
        if (!trial[MB]) begin
          rem_q <= trial[MB-1:0];
          quo_q <= {quo_q[MB-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[MB-2:0], dn_q[MB-1]};
          quo_q <= {quo_q[MB-2:0], 1'b0};
        end
        dn_q <= {dn_q[MB-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) dbusy_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: if (valid_i) begin
          if (item_i.zero_den) begin
            whole_q <= '0;
            num_q <= '0;
            den_q <= OF'(1);
            zd_q <= 1'b1;
            state_q <= StOut;
          end else begin
            neg_q <= p_n[mfa_pkg::ProdBits-1];
            q_q <= MB'(q_n);
            dn_q <= p_n[mfa_pkg::ProdBits-1] ? MB'(-p_n) : MB'(p_n);
            dd_q <= MB'(q_n);
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CB'(MB);
            dbusy_q <= 1'b1;
            zd_q <= 1'b0;
            state_q <= StWDiv;
          end
        end
        StWDiv: if (!dbusy_q) begin
          w_q <= quo_q;
          r_q <= rem_q;
          state_q <= StWFix;
        end
        StWFix: begin
          if (neg_q) begin
            if (r_q != '0) begin
              w_q <= -(w_q + 1'b1);
              r_q <= q_q - r_q;
            end else begin
              w_q <= -w_q;
            end
          end
          state_q <= StGcdStart;
        end
        StGcdStart: begin
          x_q <= r_q;
          y_q <= q_q;
          state_q <= StGcdStep;
        end
        StGcdStep: begin
          if (y_q == '0) begin
            g_q <= x_q;
            dn_q <= r_q; dd_q <= x_q;
            rem_q <= '0; quo_q <= '0;
            cnt_q <= CB'(MB); dbusy_q <= 1'b1;
            state_q <= StRNum;
          end else begin
            dn_q <= x_q; dd_q <= y_q;
            rem_q <= '0; quo_q <= '0;
            cnt_q <= CB'(MB); dbusy_q <= 1'b1;
            state_q <= StGcdDiv;
          end
        end
        StGcdDiv: if (!dbusy_q) begin
          x_q <= y_q;
          y_q <= rem_q;
          state_q <= StGcdStep;
        end
        StRNum: if (!dbusy_q) begin
          num_q <= OF'(quo_q);
          dn_q <= q_q; dd_q <= g_q;
          rem_q <= '0; quo_q <= '0;
          cnt_q <= CB'(MB); dbusy_q <= 1'b1;
          state_q <= StRDen;
        end
        StRDen: if (!dbusy_q) begin
          den_q <= OF'(quo_q);
          whole_q <= OW'(w_q);
          state_q <= StRDone;
        end
        StRDone: state_q <= StOut;
        StOut: if (pop_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/mixed_fraction_alu_unit.sv =====
// Top level of the mixed fraction ALU.
// Input queue side: drive the operands and func_i with push; a transfer
// happens on a clock edge with push high and full low.
// Result queue side: while empty is low the result ports hold the oldest
// result; a transfer happens on a clock edge with pop high.
// The front end forms the cross-multiplied fraction in its StImp, StCross1
// and StCross2 states and holds full high until it hands the item to a two-entry queue.
// The back end runs a restoring divider for the floor whole part, once
// per Euclid GCD step, and twice for the reduction; the GCD loop sets
// the rate.
// A zero denominator skips the divider and gives 0 + 0/1 with the flag set.
// Reset empties the queue and returns both ends to idle.
// A stalled receiver holds the result; the front end and queue keep taking
// items until the queue fills, then full stays high.
module mixed_fraction_alu_unit #(
  parameter int unsigned WholeBits = mfa_pkg::WholeBitsDefault,
  parameter int unsigned FracBits  = mfa_pkg::FracBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  func_i,
  input  logic signed [WholeBits-1:0] left_whole_i,
  input  logic [FracBits-1:0]         left_num_i,
  input  logic [FracBits-1:0]         left_den_i,
  input  logic signed [WholeBits-1:0] right_whole_i,
  input  logic [FracBits-1:0]         right_num_i,
  input  logic [FracBits-1:0]         right_den_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [mfa_pkg::OutWholeBits-1:0] result_whole_o,
  output logic [mfa_pkg::OutFracBits-1:0] result_num_o,
  output logic [mfa_pkg::OutFracBits-1:0] result_den_o,
  output logic                        zero_denominator_o
);

  logic f_valid, f_ready, b_valid, b_ready, q_full;
  mfa_pkg::frac_t f_item, b_item;

  assign f_ready = !q_full;

  mfa_front #(.WholeBits(WholeBits), .FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .func_i,
    .left_whole_i, .left_num_i, .left_den_i,
    .right_whole_i, .right_num_i, .right_den_i,
    .valid_o(f_valid), .ready_i(f_ready), .item_o(f_item)
  );

  mfa_queue #(.Depth(mfa_pkg::QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .full_o(q_full), .data_i(f_item),
    .valid_o(b_valid), .pop_i(b_ready), .data_o(b_item)
  );

  mfa_back u_back (
    .clk_i, .rst_ni, .valid_i(b_valid), .ready_o(b_ready), .item_i(b_item),
    .empty_o(empty), .pop_i(pop),
    .result_whole_o, .result_num_o, .result_den_o, .zero_denominator_o
  );

endmodule
